/* hdl/sss_pkg.sv */
`default_nettype none
package sss_pkg;

    localparam int MAX_POINTS_DEF = 28;
    localparam int MAX_SUBSET_DEF = 12;
    localparam int SUM_SLOTS_DEF  = 165;

    localparam int MODE_W  = 2;
    localparam int INDEX_W = 5;
    localparam int VALUE_W = 7;
    localparam int COUNT_W = 5;
    localparam int SIZE_W  = 4;
    localparam int SUM_W   = VALUE_W + 1;

    localparam logic [4:0] POINT_COUNT_RST = 5'd28;
    localparam logic [3:0] SUBSET_SIZE_RST = 4'd1;

    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FETCH   = 2'd2;

    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_SUBSET_SIZE = 1'b1;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_RUN  = 2'd1,
        PHASE_DONE = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD,
        OP_BEGIN,
        OP_FETCH_INIT,
        OP_EXHAUST,
        OP_FOUND,
        OP_TRY,
        OP_CHK,
        OP_PUSH,
        OP_SKIP,
        OP_SETP,
        OP_SETP_END,
        OP_POP,
        OP_POPP
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              phase_done;
        logic              size_big;
        logic              need_zero;
        logic              depth_zero;
        logic              can_try;
        logic              j_done;
        logic              good;
    } status_t;

endpackage
`default_nettype wire

/* hdl/sidon_subset_search_unit.sv */
`default_nettype none
// channel   signals                                        handshake
// command   start, mode, point_index, point_value         start & !busy
// result    done, subset_mask, found, exhausted, load_error  done, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data      cfg_valid & cfg_ready
//
// A load, restart or unused command passes through dispatch to the result state.
// A fetch walks the backtracking search on one shared mark bitmap: each candidate
// is tested against every stack entry, a pushed one marks its pair sums with each entry,
// and each pop clears them again, so the total time depends on the data.
// Reset clears the search state and the marks at once; the point store needs no clear.
// The result sink cannot stall; cfg_ready is always high.
module sidon_subset_search_unit #(
    parameter int MAX_POINTS = sss_pkg::MAX_POINTS_DEF,
    parameter int MAX_SUBSET = sss_pkg::MAX_SUBSET_DEF,
    parameter int SUM_SLOTS  = sss_pkg::SUM_SLOTS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [sss_pkg::MODE_W-1:0]  mode,
    input  wire logic [sss_pkg::INDEX_W-1:0] point_index,
    input  wire logic [sss_pkg::VALUE_W-1:0] point_value,
    output logic                             done,
    output logic [MAX_POINTS-1:0]            subset_mask,
    output logic                             found,
    output logic                             exhausted,
    output logic                             load_error,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [sss_pkg::COUNT_W-1:0] cfg_data
);

    sss_pkg::cmd_t    cmd;
    sss_pkg::status_t stat;

    assign cfg_ready = 1'b1;

    sss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    sss_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_SUBSET (MAX_SUBSET),
        .SUM_SLOTS  (SUM_SLOTS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .mode        (mode),
        .point_index (point_index),
        .point_value (point_value),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .subset_mask (subset_mask),
        .found       (found),
        .exhausted   (exhausted),
        .load_error  (load_error)
    );

endmodule
`default_nettype wire

/* hdl/sss_ctrl.sv */
`default_nettype none
module sss_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  sss_pkg::status_t     stat,
    output sss_pkg::cmd_t        cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_DISPATCH = 10'b0000000010,
        ST_FCHK     = 10'b0000000100,
        ST_DECIDE   = 10'b0000001000,
        ST_CHK      = 10'b0000010000,
        ST_SETP     = 10'b0000100000,
        ST_POP      = 10'b0001000000,
        ST_POPP     = 10'b0010000000,
        ST_RESULT   = 10'b0100000000,
        ST_SPARE    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   emit_reg, emit_next;

    always_comb
    begin
        state_next = state_reg;
        emit_next  = emit_reg;
        cmd.op     = sss_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = sss_pkg::OP_LATCH;
                    emit_next  = 1'b0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (stat.mode == sss_pkg::MODE_LOAD)
                begin
                    cmd.op     = sss_pkg::OP_LOAD;
                    state_next = ST_RESULT;
                end
                else if (stat.mode == sss_pkg::MODE_RESTART)
                begin
                    cmd.op     = sss_pkg::OP_BEGIN;
                    state_next = ST_RESULT;
                end
                else if (stat.mode == sss_pkg::MODE_FETCH)
                begin
                    cmd.op     = sss_pkg::OP_FETCH_INIT;
                    state_next = ST_FCHK;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_FCHK:
            begin
                if (stat.phase_done || stat.size_big)
                begin
                    cmd.op     = sss_pkg::OP_EXHAUST;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (stat.need_zero)
                begin
                    cmd.op     = sss_pkg::OP_FOUND;
                    emit_next  = 1'b1;
                    state_next = stat.depth_zero ? ST_RESULT : ST_POP;
                end
                else if (stat.can_try)
                begin
                    cmd.op     = sss_pkg::OP_TRY;
                    state_next = ST_CHK;
                end
                else if (stat.depth_zero)
                begin
                    cmd.op     = sss_pkg::OP_EXHAUST;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_CHK:
            begin
                priority if (!stat.j_done)
                begin
                    cmd.op = sss_pkg::OP_CHK;
                end
                else if (stat.good)
                begin
                    cmd.op     = sss_pkg::OP_PUSH;
                    state_next = ST_SETP;
                end
                else
                begin
                    cmd.op     = sss_pkg::OP_SKIP;
                    state_next = ST_DECIDE;
                end
            end
            ST_SETP:
            begin
                if (!stat.j_done)
                begin
                    cmd.op = sss_pkg::OP_SETP;
                end
                else
                begin
                    cmd.op     = sss_pkg::OP_SETP_END;
                    state_next = ST_DECIDE;
                end
            end
            ST_POP:
            begin
                cmd.op     = sss_pkg::OP_POP;
                state_next = ST_POPP;
            end
            ST_POPP:
            begin
                if (!stat.j_done)
                begin
                    cmd.op = sss_pkg::OP_POPP;
                end
                else
                begin
                    state_next = emit_reg ? ST_RESULT : ST_DECIDE;
                end
            end
            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            emit_reg  <= emit_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_RESULT);

endmodule
`default_nettype wire

/* hdl/sss_dpath.sv */
`default_nettype none
module sss_dpath #(
    parameter int MAX_POINTS = sss_pkg::MAX_POINTS_DEF,
    parameter int MAX_SUBSET = sss_pkg::MAX_SUBSET_DEF,
    parameter int SUM_SLOTS  = sss_pkg::SUM_SLOTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  sss_pkg::cmd_t                        cmd,
    output sss_pkg::status_t                     stat,
    input  wire logic [sss_pkg::MODE_W-1:0]      mode,
    input  wire logic [sss_pkg::INDEX_W-1:0]     point_index,
    input  wire logic [sss_pkg::VALUE_W-1:0]     point_value,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_index,
    input  wire logic [sss_pkg::COUNT_W-1:0]     cfg_data,
    output logic [MAX_POINTS-1:0]                subset_mask,
    output logic                                 found,
    output logic                                 exhausted,
    output logic                                 load_error
);

    localparam int PW  = $clog2(MAX_POINTS);
    localparam int SCW = $clog2(MAX_POINTS + 1);
    localparam int DW  = $clog2(MAX_SUBSET + 1);
    localparam int SKW = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
    localparam int SW  = (SUM_SLOTS > 1) ? $clog2(SUM_SLOTS) : 1;
    localparam int VW  = sss_pkg::VALUE_W;
    localparam int TW  = 9;

    logic [sss_pkg::COUNT_W-1:0] count_reg;
    logic [sss_pkg::SIZE_W-1:0]  size_reg;

    logic [sss_pkg::MODE_W-1:0]  mode_reg;
    logic [sss_pkg::INDEX_W-1:0] idx_reg;
    logic [VW-1:0]               val_reg;

    logic [VW-1:0]         store_mem [MAX_POINTS];
    logic [PW-1:0]         stack_idx [MAX_SUBSET];
    logic [VW-1:0]         stack_val [MAX_SUBSET];
    logic [SUM_SLOTS-1:0]  marks_reg;

    sss_pkg::phase_t       phase_reg;
    logic [DW-1:0]         depth_reg;
    logic [SCW-1:0]        scan_reg;
    logic [DW-1:0]         j_reg;
    logic [MAX_POINTS-1:0] mask_reg;
    logic [VW-1:0]         x_reg;
    logic                  good_reg;

    logic [MAX_POINTS-1:0] res_mask_reg;
    logic                  res_found_reg, res_exh_reg, res_err_reg;

    logic [PW-1:0]    rd_addr;
    logic [VW-1:0]    rd_val;
    logic [VW-1:0]    sv_j;
    logic [PW-1:0]    top_idx;
    logic [VW-1:0]    top_val;
    logic [SKW-1:0]   top_pos;
    logic [sss_pkg::SUM_W-1:0] pair_sum, self_sum, mark_sum;
    logic             pair_busy, self_busy;
    logic             mark_we, mark_val, mark_clr;
    logic [SCW-1:0]   n_eff;
    logic signed [TW-1:0] reach;
    logic             idx_ok, load_err;

    function automatic logic sum_busy(input logic [sss_pkg::SUM_W-1:0] s,
                                      input logic [SUM_SLOTS-1:0] m);
        logic r;
        r = 1'b1;
        if ({1'b0, s} < TW'(SUM_SLOTS))
            r = m[SW'(s)];
        return r;
    endfunction

    assign idx_ok   = ({1'b0, idx_reg} < 6'(MAX_POINTS));
    assign rd_addr  = (cmd.op == sss_pkg::OP_LOAD) ? PW'(idx_reg - 1'b1) : PW'(scan_reg);
    assign rd_val   = store_mem[rd_addr];
    assign sv_j     = stack_val[j_reg[SKW-1:0]];
    assign top_pos  = SKW'(depth_reg - 1'b1);
    assign top_idx  = stack_idx[top_pos];
    assign top_val  = stack_val[top_pos];
    assign pair_sum = {1'b0, x_reg} + {1'b0, sv_j};
    assign self_sum = {rd_val, 1'b0};
    assign pair_busy = sum_busy(pair_sum, marks_reg);
    assign self_busy = sum_busy(self_sum, marks_reg);
    assign load_err = !idx_ok
                    || ((idx_reg != '0) && (point_value_le(val_reg, rd_val)))
                    || ({1'b0, val_reg, 1'b0} >= TW'(SUM_SLOTS));

    function automatic logic point_value_le(input logic [VW-1:0] a, input logic [VW-1:0] b);
        return a <= b;
    endfunction

    assign n_eff = ({1'b0, count_reg} > 6'(MAX_POINTS)) ? SCW'(MAX_POINTS) : SCW'(count_reg);
    assign reach = $signed(TW'(scan_reg)) + $signed(TW'(size_reg)) - $signed(TW'(depth_reg));

    assign stat.mode       = mode_reg;
    assign stat.phase_done = (phase_reg == sss_pkg::PHASE_DONE);
    assign stat.size_big   = ({1'b0, size_reg} > 5'(MAX_SUBSET));
    assign stat.need_zero  = (TW'(size_reg) == TW'(depth_reg));
    assign stat.depth_zero = (depth_reg == '0);
    assign stat.can_try    = (reach >= 0) && (reach <= $signed(TW'(n_eff)));
    assign stat.j_done     = (j_reg == depth_reg);
    assign stat.good       = good_reg;

    // one mark write or clear a cycle: self sum on push/pop, pair sums on stack walks
    always_comb
    begin
        mark_we  = 1'b0;
        mark_val = 1'b0;
        mark_sum = pair_sum;
        mark_clr = 1'b0;
        unique case (cmd.op)
            sss_pkg::OP_LOAD, sss_pkg::OP_BEGIN:
                mark_clr = 1'b1;
            sss_pkg::OP_FETCH_INIT:
                mark_clr = (phase_reg == sss_pkg::PHASE_IDLE);
            sss_pkg::OP_PUSH:
            begin
                mark_we  = 1'b1;
                mark_val = 1'b1;
                mark_sum = {x_reg, 1'b0};
            end
            sss_pkg::OP_SETP:
            begin
                mark_we  = 1'b1;
                mark_val = 1'b1;
            end
            sss_pkg::OP_POP:
            begin
                mark_we  = 1'b1;
                mark_sum = {top_val, 1'b0};
            end
            sss_pkg::OP_POPP:
                mark_we = 1'b1;
            default:
                mark_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            marks_reg <= '0;
        else if (mark_clr)
            marks_reg <= '0;
        else if (mark_we && ({1'b0, mark_sum} < TW'(SUM_SLOTS)))
            marks_reg[SW'(mark_sum)] <= mark_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= sss_pkg::POINT_COUNT_RST;
            size_reg  <= sss_pkg::SUBSET_SIZE_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == sss_pkg::CFG_POINT_COUNT)
                count_reg <= cfg_data;
            else
                size_reg <= cfg_data[sss_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == sss_pkg::OP_LOAD && idx_ok)
            store_mem[PW'(idx_reg)] <= val_reg;
        if (cmd.op == sss_pkg::OP_PUSH)
        begin
            stack_idx[depth_reg[SKW-1:0]] <= PW'(scan_reg);
            stack_val[depth_reg[SKW-1:0]] <= x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sss_pkg::PHASE_IDLE;
            depth_reg     <= '0;
            scan_reg      <= '0;
            mask_reg      <= '0;
            j_reg         <= '0;
            good_reg      <= 1'b0;
            res_found_reg <= 1'b0;
            res_exh_reg   <= 1'b0;
            res_err_reg   <= 1'b0;
            res_mask_reg  <= '0;
        end
        else
        begin
            unique case (cmd.op)
                sss_pkg::OP_LATCH:
                begin
                    mode_reg      <= mode;
                    idx_reg       <= point_index;
                    val_reg       <= point_value;
                    res_found_reg <= 1'b0;
                    res_exh_reg   <= 1'b0;
                    res_err_reg   <= 1'b0;
                    res_mask_reg  <= '0;
                end
                sss_pkg::OP_LOAD:
                begin
                    res_err_reg <= load_err;
                    phase_reg   <= sss_pkg::PHASE_IDLE;
                    depth_reg   <= '0;
                    scan_reg    <= '0;
                    mask_reg    <= '0;
                end
                sss_pkg::OP_BEGIN:
                begin
                    phase_reg <= sss_pkg::PHASE_RUN;
                    depth_reg <= '0;
                    scan_reg  <= '0;
                    mask_reg  <= '0;
                end
                sss_pkg::OP_FETCH_INIT:
                begin
                    if (phase_reg == sss_pkg::PHASE_IDLE)
                    begin
                        phase_reg <= sss_pkg::PHASE_RUN;
                        depth_reg <= '0;
                        scan_reg  <= '0;
                        mask_reg  <= '0;
                    end
                end
                sss_pkg::OP_EXHAUST:
                begin
                    res_exh_reg <= 1'b1;
                    phase_reg   <= sss_pkg::PHASE_DONE;
                end
                sss_pkg::OP_FOUND:
                begin
                    res_found_reg <= 1'b1;
                    res_mask_reg  <= mask_reg;
                    if (depth_reg == '0)
                        phase_reg <= sss_pkg::PHASE_DONE;
                end
                sss_pkg::OP_TRY:
                begin
                    x_reg    <= rd_val;
                    good_reg <= !self_busy;
                    j_reg    <= '0;
                end
                sss_pkg::OP_CHK:
                begin
                    if (pair_busy)
                        good_reg <= 1'b0;
                    j_reg <= j_reg + 1'b1;
                end
                sss_pkg::OP_PUSH:
                begin
                    mask_reg[PW'(scan_reg)] <= 1'b1;
                    j_reg <= '0;
                end
                sss_pkg::OP_SKIP:
                    scan_reg <= scan_reg + 1'b1;
                sss_pkg::OP_SETP:
                    j_reg <= j_reg + 1'b1;
                sss_pkg::OP_SETP_END:
                begin
                    depth_reg <= depth_reg + 1'b1;
                    scan_reg  <= scan_reg + 1'b1;
                end
                sss_pkg::OP_POP:
                begin
                    x_reg              <= top_val;
                    mask_reg[top_idx]  <= 1'b0;
                    scan_reg           <= SCW'(top_idx) + 1'b1;
                    depth_reg          <= depth_reg - 1'b1;
                    j_reg              <= '0;
                end
                sss_pkg::OP_POPP:
                    j_reg <= j_reg + 1'b1;
                default:
                    j_reg <= j_reg;
            endcase
        end
    end

    assign subset_mask = res_mask_reg;
    assign found       = res_found_reg;
    assign exhausted   = res_exh_reg;
    assign load_error  = res_err_reg;

endmodule
`default_nettype wire

/* hdl/sss_checker.sv */
`default_nettype none
module sss_checker #(
    parameter int MAX_POINTS = sss_pkg::MAX_POINTS_DEF
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  done,
    input wire logic [MAX_POINTS-1:0] subset_mask,
    input wire logic                  found,
    input wire logic                  exhausted,
    input wire logic                  load_error
);

    // an accepted item keeps the block busy until its result
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after item accepted");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("block not idle after result");

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(found && exhausted) && !(load_error && (found || exhausted)))
        else $error("conflicting result flags");

    a_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !found |-> subset_mask == '0)
        else $error("mask set without a found subset");

endmodule

bind sidon_subset_search_unit sss_checker #(.MAX_POINTS(MAX_POINTS)) u_sss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .subset_mask (subset_mask),
    .found       (found),
    .exhausted   (exhausted),
    .load_error  (load_error)
);
`default_nettype wire
